/* hdl/bsmi_pkg.sv */
// shared types and codes for the bucketed sorted merge intersection core
package bsmi_pkg;

    typedef enum logic [1:0] {
        ACT_REC_A = 2'd0,
        ACT_REC_B = 2'd1,
        ACT_END_A = 2'd2,
        ACT_END_B = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_ACCEPTED = 2'd0,
        ST_WRONG    = 2'd1,
        ST_FINISHED = 2'd2
    } status_t;

    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 33;

    localparam logic [CFG_INDEX_W-1:0] CFG_KEY_BYTES    = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_BUCKET_COUNT = 1'd1;

    localparam logic [3:0] KEY_BYTES_RESET = 4'd8;
    localparam logic [3:0] KEY_BYTES_MAX   = 4'd8;
    localparam int         BUCKET_IDX_W    = 33;

    // result of one head compare
    typedef struct packed {
        logic eq;
        logic lt;
    } cmp_result_t;

endpackage

/* hdl/bucketed_sorted_merge_intersection_core.sv */
// top level: two-stream sorted merge intersection, bucket by bucket
//
// channel  | dir | handshake                     | payload
// ---------+-----+-------------------------------+-------------------------------------
// s_axis   | in  | s_axis_tvalid / s_axis_tready | tuser: action; tdata: suffix, counter
// m_axis   | out | m_axis_tvalid / m_axis_tready | tuser: flags, status; tdata: results
// cfg      | in  | cfg_wr_en (no wait)           | cfg_index, cfg_wdata
//
// one request per cycle while the output does not stall: the head compare and
// all state updates happen in the accepting cycle, the result lands in the
// output register in the next cycle; the output register is the only stage,
// s_axis_tready drops only while a result waits and m_axis_tready is low
// reset (aresetn low, synchronous) empties the heads, clears counters and
// loads a compare width of eight bytes and a bucket count of one
module bucketed_sorted_merge_intersection_core #(
    parameter int SUFFIX_BITS  = 64,
    parameter int COUNTER_BITS = 32,
    parameter int COUNT_BITS   = 40
) (
    input  logic aclk,
    input  logic aresetn,

    // config write port
    input  logic                                cfg_wr_en,
    input  logic [bsmi_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [bsmi_pkg::CFG_DATA_W-1:0]     cfg_wdata,

    // request stream
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // [1:0] action
    input  logic [1:0]                          s_axis_tuser,
    // record_suffix, record_counter from bit 0 up
    input  logic [((SUFFIX_BITS+COUNTER_BITS+7)/8)*8-1:0] s_axis_tdata,

    // result stream
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // match_valid, bucket_closed, status[1:0] from bit 0 up
    output logic [3:0]                          m_axis_tuser,
    // want_stream, match_suffix, match_counter, bucket_offset, match_total,
    // all_done from bit 0 up
    output logic [((2+SUFFIX_BITS+COUNTER_BITS+2*COUNT_BITS+7)/8)*8-1:0] m_axis_tdata
);

    localparam int OUT_RAW_W  = 2 + SUFFIX_BITS + COUNTER_BITS + 2*COUNT_BITS;
    localparam int OUT_DATA_W = ((OUT_RAW_W + 7) / 8) * 8;
    localparam int IDX_W      = bsmi_pkg::BUCKET_IDX_W;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
    localparam logic [IDX_W-1:0]      IDX_MAX   = {IDX_W{1'b1}};

    // ---------------------------------------------------------------- config
    logic [3:0]       key_bytes_reg;
    logic [IDX_W-1:0] bucket_count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_bytes_reg    <= bsmi_pkg::KEY_BYTES_RESET;
            bucket_count_reg <= IDX_W'(1);
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                bsmi_pkg::CFG_KEY_BYTES:    key_bytes_reg    <= cfg_wdata[3:0];
                bsmi_pkg::CFG_BUCKET_COUNT: bucket_count_reg <= cfg_wdata[IDX_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------- merge state
    logic [SUFFIX_BITS-1:0]  head_a_suffix_reg, head_a_suffix_next;
    logic [COUNTER_BITS-1:0] head_a_counter_reg, head_a_counter_next;
    logic                    head_a_valid_reg, head_a_valid_next;
    logic [SUFFIX_BITS-1:0]  head_b_suffix_reg, head_b_suffix_next;
    logic                    head_b_valid_reg, head_b_valid_next;
    logic                    a_ended_reg, a_ended_next;
    logic                    b_ended_reg, b_ended_next;
    logic [COUNT_BITS-1:0]   match_count_reg, match_count_next;
    logic [COUNT_BITS-1:0]   bucket_start_reg, bucket_start_next;
    logic [IDX_W-1:0]        bucket_index_reg, bucket_index_next;
    logic                    finished_reg, finished_next;

    // ---------------------------------------------------------------- request fields
    bsmi_pkg::action_t       in_action;
    logic [SUFFIX_BITS-1:0]  in_suffix;
    logic [COUNTER_BITS-1:0] in_counter;

    assign in_action  = bsmi_pkg::action_t'(s_axis_tuser);
    assign in_suffix  = s_axis_tdata[SUFFIX_BITS-1:0];
    assign in_counter = s_axis_tdata[SUFFIX_BITS +: COUNTER_BITS];

    // ---------------------------------------------------------------- handshake
    logic m_valid_reg;
    logic accept;

    // output register frees up when the waiting result is taken
    assign s_axis_tready = !m_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // stream the feeder must send now: A while A has neither head nor end mark
    logic want_now;
    assign want_now = !finished_reg && (head_a_valid_reg || a_ended_reg);

    // ---------------------------------------------------------------- head compare
    logic [SUFFIX_BITS-1:0] a_masked;
    bsmi_pkg::cmp_result_t  cmp;

    bsmi_cmp #(
        .SUFFIX_BITS (SUFFIX_BITS)
    ) u_cmp (
        .head_a    (head_a_suffix_next),
        .head_b    (head_b_suffix_next),
        .key_bytes (key_bytes_reg),
        .a_masked  (a_masked),
        .result    (cmp)
    );

    // ---------------------------------------------------------------- step logic
    bsmi_pkg::status_t       status;
    logic                    hit;
    logic                    closed;
    logic                    want_after;
    logic                    both_heads;

    always_comb begin
        head_a_suffix_next  = head_a_suffix_reg;
        head_a_counter_next = head_a_counter_reg;
        head_b_suffix_next  = head_b_suffix_reg;
        status              = bsmi_pkg::ST_ACCEPTED;
        hit                 = 1'b0;
        closed              = 1'b0;
        both_heads          = 1'b0;
        head_a_valid_next   = head_a_valid_reg;
        head_b_valid_next   = head_b_valid_reg;
        a_ended_next        = a_ended_reg;
        b_ended_next        = b_ended_reg;
        match_count_next    = match_count_reg;
        bucket_start_next   = bucket_start_reg;
        bucket_index_next   = bucket_index_reg;
        finished_next       = finished_reg;

        if (finished_reg) begin
            status = bsmi_pkg::ST_FINISHED;
        end else if (s_axis_tuser[0] != want_now) begin
            status = bsmi_pkg::ST_WRONG;
        end else begin
            unique case (in_action)
                bsmi_pkg::ACT_REC_A: begin
                    // a record after the other side ended is dropped
                    if (!b_ended_reg) begin
                        head_a_suffix_next  = in_suffix;
                        head_a_counter_next = in_counter;
                        head_a_valid_next   = 1'b1;
                    end
                end
                bsmi_pkg::ACT_REC_B: begin
                    if (!a_ended_reg) begin
                        head_b_suffix_next = in_suffix;
                        head_b_valid_next  = 1'b1;
                    end
                end
                bsmi_pkg::ACT_END_A: begin
                    a_ended_next      = 1'b1;
                    head_a_valid_next = 1'b0;
                    head_b_valid_next = 1'b0;
                end
                bsmi_pkg::ACT_END_B: begin
                    b_ended_next      = 1'b1;
                    head_a_valid_next = 1'b0;
                    head_b_valid_next = 1'b0;
                end
                default: ;
            endcase

            both_heads = head_a_valid_next && head_b_valid_next;
            if (both_heads) begin
                if (cmp.eq) begin
                    hit = 1'b1;
                    if (match_count_reg != COUNT_MAX) begin
                        match_count_next = match_count_reg + COUNT_BITS'(1);
                    end
                    head_a_valid_next = 1'b0;
                    head_b_valid_next = 1'b0;
                end else if (cmp.lt) begin
                    head_a_valid_next = 1'b0;
                end else begin
                    head_b_valid_next = 1'b0;
                end
            end

            // bucket close once both sides sent their end mark
            if (a_ended_next && b_ended_next) begin
                closed            = 1'b1;
                bucket_start_next = match_count_next;
                a_ended_next      = 1'b0;
                b_ended_next      = 1'b0;
                head_a_valid_next = 1'b0;
                head_b_valid_next = 1'b0;
                if (bucket_index_reg != IDX_MAX) begin
                    bucket_index_next = bucket_index_reg + IDX_W'(1);
                end
                if (bucket_index_next >= bucket_count_reg) begin
                    finished_next = 1'b1;
                end
            end
        end

        want_after = !finished_next && (head_a_valid_next || a_ended_next);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_a_valid_reg <= 1'b0;
            head_b_valid_reg <= 1'b0;
            a_ended_reg      <= 1'b0;
            b_ended_reg      <= 1'b0;
            match_count_reg  <= '0;
            bucket_start_reg <= '0;
            bucket_index_reg <= '0;
            finished_reg     <= 1'b0;
        end else if (accept) begin
            head_a_valid_reg <= head_a_valid_next;
            head_b_valid_reg <= head_b_valid_next;
            a_ended_reg      <= a_ended_next;
            b_ended_reg      <= b_ended_next;
            match_count_reg  <= match_count_next;
            bucket_start_reg <= bucket_start_next;
            bucket_index_reg <= bucket_index_next;
            finished_reg     <= finished_next;
        end
    end

    // head payloads only matter while their valid bit is set
    always_ff @(posedge aclk) begin
        if (accept) begin
            head_a_suffix_reg  <= head_a_suffix_next;
            head_a_counter_reg <= head_a_counter_next;
            head_b_suffix_reg  <= head_b_suffix_next;
        end
    end

    // ---------------------------------------------------------------- output register
    logic                    out_want_reg;
    logic                    out_hit_reg;
    logic [SUFFIX_BITS-1:0]  out_suffix_reg;
    logic [COUNTER_BITS-1:0] out_counter_reg;
    logic                    out_closed_reg;
    logic [COUNT_BITS-1:0]   out_offset_reg;
    logic [COUNT_BITS-1:0]   out_total_reg;
    bsmi_pkg::status_t       out_status_reg;
    logic                    out_done_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            out_want_reg    <= want_after;
            out_hit_reg     <= hit;
            out_suffix_reg  <= hit ? a_masked : '0;
            out_counter_reg <= hit ? head_a_counter_next : '0;
            out_closed_reg  <= closed;
            // offset of the closing bucket is the start count before the update
            out_offset_reg  <= closed ? bucket_start_reg : '0;
            out_total_reg   <= match_count_next;
            out_status_reg  <= status;
            out_done_reg    <= finished_next;
        end
    end

    logic [OUT_RAW_W-1:0] out_raw;

    assign out_raw = {out_done_reg, out_total_reg, out_offset_reg,
                      out_counter_reg, out_suffix_reg, out_want_reg};

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = OUT_DATA_W'(out_raw);
    assign m_axis_tuser  = {out_status_reg, out_closed_reg, out_hit_reg};

    // ---------------------------------------------------------------- checks
    // a finished block always asks for stream A
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && out_done_reg |-> !out_want_reg)
        else $error("finished block asks for stream B");

    // the end mark that closes a bucket clears both heads, so a close never comes with a match
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> !(out_hit_reg && out_closed_reg))
        else $error("match and bucket close in one result");

    // ignored requests leave no match and no close behind
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && out_status_reg != bsmi_pkg::ST_ACCEPTED
            |-> !out_hit_reg && !out_closed_reg)
        else $error("ignored request produced a result");

    // every accepted request shows up as a result in the next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> m_valid_reg)
        else $error("accepted request lost");

    // the match counter never goes back
    assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) |-> match_count_reg >= $past(match_count_reg))
        else $error("match counter went down");

endmodule

/* hdl/bsmi_cmp.sv */
// masked suffix compare of the two stream heads
module bsmi_cmp #(
    parameter int SUFFIX_BITS = 64
) (
    input  logic [SUFFIX_BITS-1:0] head_a,
    input  logic [SUFFIX_BITS-1:0] head_b,
    input  logic [3:0]             key_bytes,
    output logic [SUFFIX_BITS-1:0] a_masked,
    output bsmi_pkg::cmp_result_t  result
);

    logic [3:0]             nbytes;
    logic [SUFFIX_BITS-1:0] mask;
    logic [SUFFIX_BITS-1:0] b_masked;

    // byte counts above eight act as eight
    assign nbytes = (key_bytes > bsmi_pkg::KEY_BYTES_MAX) ?
                    bsmi_pkg::KEY_BYTES_MAX : key_bytes;

    for (genvar g = 0; g < SUFFIX_BITS; g++) begin : g_mask
        assign mask[g] = (4'(g / 8) < nbytes);
    end

    assign a_masked  = head_a & mask;
    assign b_masked  = head_b & mask;
    assign result.eq = (a_masked == b_masked);
    assign result.lt = (a_masked < b_masked);

endmodule

/* test/tb_bucketed_sorted_merge_intersection_core.sv */
// self-checking testbench for the bucketed sorted merge intersection core
module tb_bucketed_sorted_merge_intersection_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SUF_W       = 64;
    localparam int CNT_W       = 32;
    localparam int TOTAL_W     = 40;
    localparam int S_DATA_W    = ((SUF_W + CNT_W + 7) / 8) * 8;
    localparam int M_DATA_W    = ((2 + SUF_W + CNT_W + 2 * TOTAL_W + 7) / 8) * 8;
    localparam int PHASE_REQS  = 265;
    localparam int STALL_LIMIT = 3000;
    localparam int MAX_REPORTS = 20;

    // one request on the input stream
    typedef struct packed {
        bsmi_pkg::action_t act;
        bit [63:0]         suf;
        bit [31:0]         cnt;
    } merge_req_t;

    // everything the core holds, configuration included
    typedef struct packed {
        bit [63:0]   a_suf;
        bit [31:0]   a_cnt;
        bit          a_vld;
        bit [63:0]   b_suf;
        bit          b_vld;
        bit          a_end;
        bit          b_end;
        bit [39:0]   match_cnt;
        bit [39:0]   bkt_start;
        bit [32:0]   bkt_idx;
        bit          done;
        bit [3:0]    sfx;
        bit [32:0]   bkt_count;
    } merge_state_t;

    // one result on the output stream
    typedef struct packed {
        bit                want;
        bit                hit;
        bit [63:0]         hit_suffix;
        bit [31:0]         hit_counter;
        bit                closed;
        bit [39:0]         offset;
        bit [39:0]         total;
        bsmi_pkg::status_t status;
        bit                done;
    } merge_result_t;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic                             cfg_wr_en = 1'b0;
    logic [bsmi_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [bsmi_pkg::CFG_DATA_W-1:0]  cfg_wdata = '0;

    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    // [1:0] action
    logic [1:0]             s_axis_tuser  = '0;
    // record_suffix [63:0], record_counter [95:64]
    logic [S_DATA_W-1:0]    s_axis_tdata  = '0;

    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // match_valid [0], bucket_closed [1], status [3:2]
    logic [3:0]             m_axis_tuser;
    // want_stream [0], match_suffix [64:1], match_counter [96:65],
    // bucket_offset [136:97], match_total [176:137], all_done [177], zero pad above
    logic [M_DATA_W-1:0]    m_axis_tdata;

    bucketed_sorted_merge_intersection_core dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 aclk = ~aclk;

    // requests waiting for the driver, and predicted results waiting for the core
    merge_req_t    pending_requests[$];
    merge_result_t awaited_results[$];

    // plan_state tracks the core as requests are queued, so the generator knows
    // which stream the core will ask for; merge_state follows accepted requests
    merge_state_t  plan_state;
    merge_state_t  merge_state;

    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int planned_count = 0;
    int mismatches = 0;
    int stall_cycles = 0;

    // run statistics, taken from the predictions of accepted requests
    int stat_requests = 0;
    int stat_wrong = 0;
    int stat_after_done = 0;
    int stat_hits = 0;
    int stat_closes = 0;

    // compared bits: min(8*bytes, 64) low bits, zero bytes compare nothing
    function automatic bit [63:0] key_mask(input bit [3:0] nbytes);
        int bits;
        bits = (nbytes > 4'd8) ? 64 : 8 * nbytes;
        return (bits >= 64) ? {64{1'b1}} : ((64'd1 << bits) - 64'd1);
    endfunction

    // stream the core asks for next: A while A has no head and has not ended
    function automatic bit want_of(input merge_state_t st);
        if (st.done)
            return 1'b0;
        return !(!st.a_vld && !st.a_end);
    endfunction

    function automatic void predict_merge_step(inout merge_state_t st,
                                               input merge_req_t rq,
                                               output merge_result_t r);
        bit [63:0] mk;
        bit [63:0] ka;
        bit [63:0] kb;
        r = '0;
        if (st.done) begin
            r.status = bsmi_pkg::ST_FINISHED;
        end else if (rq.act[0] != want_of(st)) begin
            r.status = bsmi_pkg::ST_WRONG;
        end else begin
            r.status = bsmi_pkg::ST_ACCEPTED;
            case (rq.act)
                bsmi_pkg::ACT_REC_A: begin
                    // dropped if B already closed its side of the bucket
                    if (!st.b_end) begin
                        st.a_suf = rq.suf;
                        st.a_cnt = rq.cnt;
                        st.a_vld = 1'b1;
                    end
                end
                bsmi_pkg::ACT_REC_B: begin
                    if (!st.a_end) begin
                        st.b_suf = rq.suf;
                        st.b_vld = 1'b1;
                    end
                end
                bsmi_pkg::ACT_END_A: begin
                    st.a_end = 1'b1;
                    st.a_vld = 1'b0;
                    st.b_vld = 1'b0;
                end
                default: begin
                    st.b_end = 1'b1;
                    st.a_vld = 1'b0;
                    st.b_vld = 1'b0;
                end
            endcase

            if (st.a_vld && st.b_vld) begin
                mk = key_mask(st.sfx);
                ka = st.a_suf & mk;
                kb = st.b_suf & mk;
                if (ka == kb) begin
                    r.hit         = 1'b1;
                    r.hit_suffix  = ka;
                    r.hit_counter = st.a_cnt;
                    if (st.match_cnt != {40{1'b1}})
                        st.match_cnt = st.match_cnt + 40'd1;
                    st.a_vld = 1'b0;
                    st.b_vld = 1'b0;
                end else if (ka < kb) begin
                    st.a_vld = 1'b0;
                end else begin
                    st.b_vld = 1'b0;
                end
            end

            // both sides ended: close the bucket, maybe finish
            if (st.a_end && st.b_end) begin
                r.closed     = 1'b1;
                r.offset     = st.bkt_start;
                st.bkt_start = st.match_cnt;
                st.a_end     = 1'b0;
                st.b_end     = 1'b0;
                st.a_vld     = 1'b0;
                st.b_vld     = 1'b0;
                if (st.bkt_idx != {33{1'b1}})
                    st.bkt_idx = st.bkt_idx + 33'd1;
                if (st.bkt_idx >= st.bkt_count)
                    st.done = 1'b1;
            end
        end
        r.want  = want_of(st);
        r.total = st.match_cnt;
        r.done  = st.done;
    endfunction

    // ------------------------------------------------------------------
    // request driver: holds data stable while valid and not ready
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : drive_requests
        merge_req_t    cur_req;
        merge_result_t r;
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                predict_merge_step(merge_state, cur_req, r);
                awaited_results.push_back(r);
                stat_requests++;
                if (r.status == bsmi_pkg::ST_WRONG)
                    stat_wrong++;
                if (r.status == bsmi_pkg::ST_FINISHED)
                    stat_after_done++;
                if (r.hit)
                    stat_hits++;
                if (r.closed)
                    stat_closes++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (pending_requests.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
                    cur_req = pending_requests.pop_front();
                    s_axis_tuser  <= cur_req.act;
                    s_axis_tdata  <= {cur_req.cnt, cur_req.suf};
                    s_axis_tvalid <= 1'b1;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver stalls
    always @(posedge aclk) begin
        m_axis_tready <= aresetn && ($urandom_range(0, 99) >= rx_idle_pct);
    end

    task automatic check_field(input string name, input bit [63:0] exp_v,
                               input bit [63:0] got_v);
        if (exp_v !== got_v) begin
            if (mismatches < MAX_REPORTS)
                $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, got_v);
            mismatches++;
        end
    endtask

    // ------------------------------------------------------------------
    // result monitor: every accepted result against the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : check_results
        merge_result_t r;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (awaited_results.size() == 0) begin
                if (mismatches < MAX_REPORTS)
                    $display("%0t: unexpected result, expected none, actual tuser %h tdata %h",
                             $time, m_axis_tuser, m_axis_tdata);
                mismatches++;
            end else begin
                r = awaited_results.pop_front();
                check_field("want_stream",   r.want,        m_axis_tdata[0]);
                check_field("match_valid",   r.hit,         m_axis_tuser[0]);
                check_field("match_suffix",  r.hit_suffix,  m_axis_tdata[64:1]);
                check_field("match_counter", r.hit_counter, m_axis_tdata[96:65]);
                check_field("bucket_closed", r.closed,      m_axis_tuser[1]);
                check_field("bucket_offset", r.offset,      m_axis_tdata[136:97]);
                check_field("match_total",   r.total,       m_axis_tdata[176:137]);
                check_field("status",        r.status,      m_axis_tuser[3:2]);
                check_field("all_done",      r.done,        m_axis_tdata[177]);
                check_field("tdata padding", 64'd0,         m_axis_tdata[M_DATA_W-1:178]);
            end
        end
    end

    // watchdog: too long without any handshake on either side
    always @(posedge aclk) begin
        if (!aresetn || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
            $display("tb_bucketed_sorted_merge_intersection_core: FAIL");
            $finish;
        end
    end

    // register write while idle; both model copies follow
    task automatic write_register(input logic [bsmi_pkg::CFG_INDEX_W-1:0] idx,
                                  input bit [32:0] value);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == bsmi_pkg::CFG_KEY_BYTES) begin
            plan_state.sfx  = value[3:0];
            merge_state.sfx = value[3:0];
        end else begin
            plan_state.bkt_count  = value;
            merge_state.bkt_count = value;
        end
        @(negedge aclk);
    endtask

    // wait for the queue and the core to drain, then the output stage latency
    task automatic wait_idle();
        do
            @(negedge aclk);
        while (pending_requests.size() != 0 || s_axis_tvalid || awaited_results.size() != 0);
        repeat (3) @(negedge aclk);
    endtask

    task automatic queue_request(input merge_req_t rq, output bit closed);
        merge_result_t r;
        predict_merge_step(plan_state, rq, r);
        pending_requests.push_back(rq);
        if (r.status == bsmi_pkg::ST_ACCEPTED)
            planned_count++;
        closed = r.closed;
    endtask

    function automatic merge_req_t make_req(input bsmi_pkg::action_t act,
                                            input bit [63:0] suf,
                                            input bit [31:0] cnt);
        merge_req_t rq;
        rq.act = act;
        rq.suf = suf;
        rq.cnt = cnt;
        return rq;
    endfunction

    // one bucket: sorted A and B lists sharing some keys, fed in the order the
    // core asks for, with a sprinkle of random requests; some buckets unsorted
    task automatic plan_bucket();
        merge_req_t a_list[$];
        merge_req_t b_list[$];
        merge_req_t rq;
        bit [63:0]  mk;
        bit [63:0]  key;
        int         n;
        int         pick;
        bit         ordered;
        bit         closed;
        mk      = key_mask(plan_state.sfx);
        ordered = ($urandom_range(0, 9) != 0);
        n       = $urandom_range(0, ($urandom_range(0, 7) == 0) ? 16 : 6);
        key     = {$urandom, $urandom} & (mk >> 1);
        for (int i = 0; i < n; i++) begin
            if (!ordered)
                key = {$urandom, $urandom} & mk;
            else if (mk - key < 64'd3)
                key = mk;
            else
                key = key + $urandom_range(0, 3);
            // 0: A only, 1: B only, 2: both streams (a likely match)
            pick = $urandom_range(0, 2);
            // bits above the compared width are random and must not matter
            if (pick != 1)
                a_list.push_back(make_req(bsmi_pkg::ACT_REC_A,
                                          key | ({$urandom, $urandom} & ~mk), $urandom));
            if (pick != 0)
                b_list.push_back(make_req(bsmi_pkg::ACT_REC_B,
                                          key | ({$urandom, $urandom} & ~mk), $urandom));
        end
        closed = 1'b0;
        while (!closed && !plan_state.done) begin
            if ($urandom_range(0, 99) < 8)
                rq = make_req(bsmi_pkg::action_t'($urandom_range(0, 3)),
                              {$urandom, $urandom}, $urandom);
            else if (want_of(plan_state) == 1'b0)
                rq = (a_list.size() != 0) ? a_list.pop_front()
                                          : make_req(bsmi_pkg::ACT_END_A,
                                                     {$urandom, $urandom}, $urandom);
            else
                rq = (b_list.size() != 0) ? b_list.pop_front()
                                          : make_req(bsmi_pkg::ACT_END_B,
                                                     {$urandom, $urandom}, $urandom);
            queue_request(rq, closed);
        end
    endtask

    // ------------------------------------------------------------------
    // stimulus: directed cases, six random phases, then the finishing bucket
    // ------------------------------------------------------------------
    initial begin : stimulus
        bit         c;
        bit         held;
        bit [3:0]   sfx_value;
        bit [32:0]  count_value;
        plan_state           = '0;
        plan_state.sfx       = bsmi_pkg::KEY_BYTES_RESET;
        plan_state.bkt_count = 33'd1;
        merge_state          = plan_state;
        held                 = 1'b0;
        tx_idle_pct          = 38;
        rx_idle_pct          = 87;

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reset count of one would finish on the first close
        write_register(bsmi_pkg::CFG_BUCKET_COUNT, {33{1'b1}});

        // directed, full 8-byte compare
        queue_request(make_req(bsmi_pkg::ACT_REC_B, 64'd1, 32'd1), c);      // wrong stream
        queue_request(make_req(bsmi_pkg::ACT_REC_A, {64{1'b1}}, {32{1'b1}}), c);
        queue_request(make_req(bsmi_pkg::ACT_REC_B, {64{1'b1}}, 32'd0), c); // match, all ones
        queue_request(make_req(bsmi_pkg::ACT_REC_A, 64'd0, 32'd0), c);
        queue_request(make_req(bsmi_pkg::ACT_REC_B, 64'd0, {32{1'b1}}), c); // match, zeros
        queue_request(make_req(bsmi_pkg::ACT_REC_A, 64'd5, 32'h1234), c);
        queue_request(make_req(bsmi_pkg::ACT_REC_B, 64'd3, 32'd0), c);      // B smaller
        queue_request(make_req(bsmi_pkg::ACT_REC_B, 64'd7, 32'd0), c);      // A smaller
        queue_request(make_req(bsmi_pkg::ACT_REC_A, 64'd7, 32'h5678), c);   // match
        queue_request(make_req(bsmi_pkg::ACT_END_A, {64{1'b1}}, {32{1'b1}}), c);
        queue_request(make_req(bsmi_pkg::ACT_REC_B, 64'd9, 32'd0), c);      // after A ended
        queue_request(make_req(bsmi_pkg::ACT_END_B, 64'd0, 32'd0), c);      // close
        queue_request(make_req(bsmi_pkg::ACT_REC_A, 64'd1, 32'd1), c);
        queue_request(make_req(bsmi_pkg::ACT_END_B, 64'd0, 32'd0), c);      // drops A head
        queue_request(make_req(bsmi_pkg::ACT_REC_A, 64'd2, 32'd2), c);      // after B ended
        queue_request(make_req(bsmi_pkg::ACT_END_A, 64'd0, 32'd0), c);      // close
        queue_request(make_req(bsmi_pkg::ACT_END_A, 64'd0, 32'd0), c);      // empty bucket
        queue_request(make_req(bsmi_pkg::ACT_END_B, 64'd0, 32'd0), c);
        queue_request(make_req(bsmi_pkg::ACT_END_B, 64'd0, 32'd0), c);      // wrong stream
        queue_request(make_req(bsmi_pkg::ACT_REC_A, 64'h8000_0000_0000_0000,
                               32'h8000_0000), c);
        queue_request(make_req(bsmi_pkg::ACT_REC_B, 64'h7FFF_FFFF_FFFF_FFFF, 32'd0), c);
        queue_request(make_req(bsmi_pkg::ACT_REC_B, 64'h8000_0000_0000_0000, 32'd0), c);
        queue_request(make_req(bsmi_pkg::ACT_END_B, 64'd0, 32'd0), c);
        queue_request(make_req(bsmi_pkg::ACT_END_A, 64'd0, 32'd0), c);
        wait_idle();

        for (int p = 0; p < 6; p++) begin
            // idling: sender light / receiver heavy, then swapped, then none
            case (p / 2)
                0:       begin tx_idle_pct = 38; rx_idle_pct = 87; end
                1:       begin tx_idle_pct = 87; rx_idle_pct = 38; end
                default: begin tx_idle_pct = 0;  rx_idle_pct = 0;  end
            endcase
            // suffix width 15 behaves as 8, width 0 makes every pair tie
            case (p)
                0:       sfx_value = 4'd8;
                1:       sfx_value = 4'd1;
                2:       sfx_value = 4'd0;
                3:       sfx_value = 4'd15;
                4:       sfx_value = 4'd2;
                default: sfx_value = 4'd4;
            endcase
            // bucket counts stay well above the buckets closed so far
            case (p / 2)
                0:       count_value = {33{1'b1}};
                1:       count_value = 33'h1_0000_0000;
                default: count_value = 33'd5000;
            endcase
            write_register(bsmi_pkg::CFG_KEY_BYTES, sfx_value);
            write_register(bsmi_pkg::CFG_BUCKET_COUNT, count_value);
            planned_count = 0;
            while (planned_count < PHASE_REQS) begin
                plan_bucket();
                // hold the sender once until the core has returned everything
                if (!held && planned_count >= PHASE_REQS / 2) begin
                    held = 1'b1;
                    wait_idle();
                end
            end
            wait_idle();
        end

        // a zero count acts as one: the next close finishes the core, then
        // everything afterwards is ignored
        write_register(bsmi_pkg::CFG_KEY_BYTES, 4'd7);
        write_register(bsmi_pkg::CFG_BUCKET_COUNT, 33'd0);
        while (!plan_state.done)
            plan_bucket();
        for (int i = 0; i < 12; i++)
            queue_request(make_req(bsmi_pkg::action_t'($urandom_range(0, 3)),
                                   {$urandom, $urandom}, $urandom), c);
        wait_idle();

        $display("covered %0d requests (%0d wrong stream, %0d after done), %0d matches,",
                 stat_requests, stat_wrong, stat_after_done, stat_hits);
        $display("%0d buckets closed over six compare widths and three bucket counts",
                 stat_closes);
        if (mismatches == 0)
            $display("tb_bucketed_sorted_merge_intersection_core: PASS");
        else
            $display("tb_bucketed_sorted_merge_intersection_core: FAIL");
        $finish;
    end

endmodule

/* bucketed_sorted_merge_intersection_core.f */
hdl/bsmi_pkg.sv
hdl/bsmi_cmp.sv
hdl/bucketed_sorted_merge_intersection_core.sv
test/tb_bucketed_sorted_merge_intersection_core.sv
